// ===== hdl/gyro_window_fall_classifier_core_defines.svh =====
// assertion macros shared by the gyro window fall classifier
`ifndef GYRO_WINDOW_FALL_CLASSIFIER_CORE_DEFINES_SVH
`define GYRO_WINDOW_FALL_CLASSIFIER_CORE_DEFINES_SVH

// property checked on every rising edge outside reset
`define GWFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define GWFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/gwfc_pkg.sv =====
package gwfc_pkg;

  // window geometry
  localparam int WINDOW_DEPTH = 8;
  localparam int SAMPLE_W     = 16;
  localparam int LIMIT_W      = 15;
  localparam int WEIGHT_W     = 9;
  localparam int PROD_W       = SAMPLE_W + WEIGHT_W + 1;
  localparam int SUM_W        = PROD_W + 1;
  localparam int FRAC_BITS    = 8;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_STABLE_LIMIT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FALL_LIMIT      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_CURRENT  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_PREVIOUS = 2'd3;

  // reset values of the registers
  localparam logic [LIMIT_W-1:0]  STABLE_LIMIT_RESET = 15'd10;
  localparam logic [LIMIT_W-1:0]  FALL_LIMIT_RESET   = 15'd100;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET       = 9'd128;

  // tilt state codes
  localparam logic [1:0] TILT_STABLE   = 2'd0;
  localparam logic [1:0] TILT_UNSTABLE = 2'd1;
  localparam logic [1:0] TILT_FALLING  = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LIMIT_W-1:0] limit_t;

  // true when the sample lies within plus or minus the limit
  function automatic logic in_band(input sample_t s, input limit_t lim);
    logic signed [SAMPLE_W:0] s_ext;
    logic signed [SAMPLE_W:0] lim_ext;
    begin
      s_ext   = {s[SAMPLE_W-1], s};
      lim_ext = {2'b00, lim};
      in_band = (s_ext <= lim_ext) && (s_ext >= -lim_ext);
    end
  endfunction

endpackage

// ===== hdl/gwfc_cell.sv =====
module gwfc_cell
  import gwfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    shift_en,
  input  sample_t sample_in,
  input  limit_t  stable_limit,
  output sample_t sample_out,
  output logic    in_range
);

  sample_t sample;

  // one window slot, cleared at reset, takes sample_in on each shifted item
  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (shift_en) begin
      sample <= sample_in;
    end
  end

  assign sample_out = sample;

  // per-slot band check against the current limit
  assign in_range = in_band(sample, stable_limit);

endmodule

// ===== hdl/gyro_window_fall_classifier_core.sv =====
// channel | signals                          | direction
// input   | in_valid, in_ready, rate_sample  | item in
// output  | out_valid, out_ready, tilt_state, weighted_rate | item out
// config  | cfg_we, cfg_index, cfg_data      | register write
//
// one item per cycle sustained while the output is not stalled; a result passes through the
// product register stage, then the sum/saturate/compare output register.
// the window is a row of slot cells shifting one place per item, all band
// checks run in parallel against the stable limit.
// reset clears the window, the previous sample and the pipeline.
// a stalled output holds its item and backs up into the product stage and input.
module gyro_window_fall_classifier_core
  import gwfc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [15:0]      rate_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              tilt_state,
  output logic signed [15:0]      weighted_rate,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [LIMIT_W-1:0]      cfg_data
);

  `include "gyro_window_fall_classifier_core_defines.svh"

  limit_t                stable_limit;
  limit_t                fall_limit;
  logic [WEIGHT_W-1:0]   weight_current;
  logic [WEIGHT_W-1:0]   weight_previous;

  sample_t               previous_sample;
  logic                  accept;
  logic                  s1_valid;
  logic                  s1_advance;
  logic                  s1_stable;
  logic signed [PROD_W-1:0] p_cur;
  logic signed [PROD_W-1:0] p_prev;

  sample_t               cell_q [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] cell_ok;
  logic                  stable_now;

  logic signed [SUM_W-1:0] sum;
  sample_t               sat;
  logic signed [SAMPLE_W:0] sat_ext;
  logic signed [SAMPLE_W:0] flim_ext;
  logic                  falling;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_limit    <= STABLE_LIMIT_RESET;
      fall_limit      <= FALL_LIMIT_RESET;
      weight_current  <= WEIGHT_RESET;
      weight_previous <= WEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STABLE_LIMIT:    stable_limit    <= cfg_data;
        REG_FALL_LIMIT:      fall_limit      <= cfg_data;
        REG_WEIGHT_CURRENT:  weight_current  <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_PREVIOUS: weight_previous <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and stage flow
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign accept     = in_valid && in_ready;

  // window: row of cells, newest sample enters slot 0
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    sample_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = rate_sample;
    end else begin : g_link
      assign cell_in = cell_q[i-1];
    end
    gwfc_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .shift_en     (accept),
      .sample_in    (cell_in),
      .stable_limit (stable_limit),
      .sample_out   (cell_q[i]),
      .in_range     (cell_ok[i])
    );
  end

  // window after this item: new sample plus all but the oldest slot
  assign stable_now = in_band(rate_sample, stable_limit) &&
                      (&cell_ok[WINDOW_DEPTH-2:0]);

  // previous sample
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
    end else if (accept) begin
      previous_sample <= rate_sample;
    end
  end

  // stage 1: weighted products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_cur     <= PROD_W'(rate_sample * $signed({1'b0, weight_current}));
      p_prev    <= PROD_W'(previous_sample * $signed({1'b0, weight_previous}));
      s1_stable <= stable_now;
    end
  end

  // stage 2: sum, floor shift, saturate, fall compare
  assign sum = SUM_W'(p_cur) + SUM_W'(p_prev);

  always_comb begin
    if (sum[SUM_W-1:FRAC_BITS+SAMPLE_W-1] == '0 ||
        sum[SUM_W-1:FRAC_BITS+SAMPLE_W-1] == '1) begin
      sat = sum[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  assign sat_ext  = {sat[SAMPLE_W-1], sat};
  assign flim_ext = {2'b00, fall_limit};
  assign falling  = (sat_ext > flim_ext) || (sat_ext < -flim_ext);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      weighted_rate <= sat;
      if (s1_stable) begin
        tilt_state <= TILT_STABLE;
      end else if (falling) begin
        tilt_state <= TILT_FALLING;
      end else begin
        tilt_state <= TILT_UNSTABLE;
      end
    end
  end

  // checks
  `GWFC_ASSERT(a_accept_fills_s1, accept |=> s1_valid,
    "accepted item missing from product stage")
  `GWFC_ASSERT(a_s1_held_on_stall,
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(p_cur)),
    "product stage lost item on stall")
  `GWFC_ASSERT(a_state_code,
    out_valid |-> (tilt_state == TILT_STABLE || tilt_state == TILT_UNSTABLE ||
                   tilt_state == TILT_FALLING),
    "bad tilt state code")
  `GWFC_ASSERT(a_falling_bound,
    (out_valid && tilt_state == TILT_FALLING) |->
      ($signed({weighted_rate[15], weighted_rate}) > $signed({2'b00, fall_limit}) ||
       $signed({weighted_rate[15], weighted_rate}) < -$signed({2'b00, fall_limit})),
    "falling within fall limit")
  `GWFC_ASSERT_ALWAYS(a_reset_clears, rst |=> (!s1_valid && !out_valid),
    "pipeline not empty after reset")

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gwfc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 112;

  typedef struct packed {
    logic [1:0]         tilt;
    logic signed [15:0] rate;
  } tilt_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [15:0]     rate_sample = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             tilt_state;
  logic signed [15:0]     weighted_rate;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]     cfg_data = '0;

  gyro_window_fall_classifier_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rate_sample(rate_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .tilt_state(tilt_state),
    .weighted_rate(weighted_rate),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // shadow copy of the window, previous sample and registers
  logic signed [15:0]  win_copy [WINDOW_DEPTH];
  int unsigned         slot_copy = 0;
  logic signed [15:0]  prev_copy = '0;
  logic [LIMIT_W-1:0]  stable_lim = STABLE_LIMIT_RESET;
  logic [LIMIT_W-1:0]  fall_lim = FALL_LIMIT_RESET;
  logic [WEIGHT_W-1:0] wt_cur = WEIGHT_RESET;
  logic [WEIGHT_W-1:0] wt_prev = WEIGHT_RESET;

  logic signed [15:0] pending_samples [$];
  tilt_result_t       due_results [$];

  bit idle_on = 1'b1;
  int errors = 0;
  int in_gap = 0;
  int out_wait = 0;
  int hold_left = 0;
  int long_holds = 0;
  int cycle_count = 0;

  // store the sample, then classify the window and the weighted rate
  function automatic tilt_result_t classify_sample(input logic signed [15:0] s);
    tilt_result_t r;
    int i, sv, pv, cw, pw, band, fall, acc;
    bit calm;
    win_copy[slot_copy] = s;
    slot_copy = (slot_copy + 1) % WINDOW_DEPTH;
    band = stable_lim;
    fall = fall_lim;
    calm = 1'b1;
    for (i = 0; i < WINDOW_DEPTH; i++) begin
      sv = win_copy[i];
      if (sv > band || sv < -band) calm = 1'b0;
    end
    sv = s;
    pv = prev_copy;
    cw = wt_cur;
    pw = wt_prev;
    acc = (sv * cw + pv * pw) >>> FRAC_BITS;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    r.rate = acc[15:0];
    if (calm) r.tilt = TILT_STABLE;
    else if (acc > fall || acc < -fall) r.tilt = TILT_FALLING;
    else r.tilt = TILT_UNSTABLE;
    prev_copy = s;
    return r;
  endfunction

  // sample generator: near the stable band, full range, near the fall limit, extremes
  function automatic logic signed [15:0] draw_sample(input int kind);
    int v, band;
    band = stable_lim;
    case (kind)
      3: v = int'($urandom_range(0, 65535)) - 32768;
      4: begin
        v = int'(fall_lim) + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1)) v = -v;
      end
      5: begin
        case ($urandom_range(0, 3))
          0: v = 32767;
          1: v = -32768;
          2: v = -1;
          default: v = 0;
        endcase
      end
      default: v = int'($urandom_range(0, 2 * band + 6)) - band - 3;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // register write, shadow copy updated alongside
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_STABLE_LIMIT: stable_lim = val;
      REG_FALL_LIMIT: fall_lim = val;
      REG_WEIGHT_CURRENT: wt_cur = val[WEIGHT_W-1:0];
      default: wt_prev = val[WEIGHT_W-1:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold off until every queued item has produced its result
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin : drive_items
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back(classify_sample(rate_sample));
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0 || pending_samples.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end else begin
          rate_sample <= pending_samples.pop_front();
          in_valid <= 1'b1;
          in_gap = idle_on ? $urandom_range(0, 4) : 0;
        end
      end
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk) begin : collect_results
    tilt_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected item tilt_state %0d weighted_rate %0d",
                   $time, tilt_state, weighted_rate);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (tilt_state !== want.tilt) begin
            $display("%0t: tilt_state expected %0d got %0d", $time, want.tilt, tilt_state);
            errors++;
          end
          if (weighted_rate !== want.rate) begin
            $display("%0t: weighted_rate expected %0d got %0d",
                     $time, $signed(want.rate), weighted_rate);
            errors++;
          end
        end
        out_wait = idle_on ? $urandom_range(0, 4) : 0;
        // long hold-off while the sender keeps pushing
        if (pending_samples.size() > 40 &&
            (long_holds == 0 || $urandom_range(0, 199) == 0)) begin
          hold_left = $urandom_range(40, 80);
          long_holds++;
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (out_wait > 0) begin
        out_ready <= 1'b0;
        out_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // test sequence
  initial begin : run_test
    int i, p, n, kind, run;
    static int dir_reset [11] = '{5, -5, 10, -10, 11, 300, -300, 32767, -32768, -1, 0};
    static int dir_sat [12] = '{32767, 32767, -32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0};
    logic [LIMIT_W-1:0] v;
    for (i = 0; i < WINDOW_DEPTH; i++) win_copy[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: stable, unstable and falling, field extremes
    foreach (dir_reset[j]) pending_samples.push_back(dir_reset[j][15:0]);
    wait_idle();

    // zero stable band, widest fall band, weights above unity saturate
    write_reg(REG_STABLE_LIMIT, '0);
    write_reg(REG_FALL_LIMIT, 15'h7fff);
    write_reg(REG_WEIGHT_CURRENT, 15'd511);
    write_reg(REG_WEIGHT_PREVIOUS, 15'd511);
    foreach (dir_sat[j]) pending_samples.push_back(dir_sat[j][15:0]);

    // random phases, each with its own settings
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      idle_on = ($urandom_range(0, 3) != 0);
      if (p == 0) begin
        write_reg(REG_STABLE_LIMIT, 15'h7fff);
        write_reg(REG_FALL_LIMIT, '0);
        write_reg(REG_WEIGHT_CURRENT, '0);
        write_reg(REG_WEIGHT_PREVIOUS, 15'd256);
      end else begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = 15'h7fff;
          default: v = LIMIT_W'($urandom_range(0, 200));
        endcase
        write_reg(REG_STABLE_LIMIT, v);
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = 15'h7fff;
          default: v = LIMIT_W'($urandom_range(0, 2000));
        endcase
        write_reg(REG_FALL_LIMIT, v);
        for (i = 0; i < 2; i++) begin
          case ($urandom_range(0, 4))
            0: v = '0;
            1: v = 15'd256;
            2: v = 15'd511;
            3: v = LIMIT_W'($urandom_range(0, 32767));
            default: v = LIMIT_W'($urandom_range(0, 256));
          endcase
          write_reg(i == 0 ? REG_WEIGHT_CURRENT : REG_WEIGHT_PREVIOUS, v);
        end
      end
      // bursts of one sample kind, half of the kinds near the stable band
      n = 0;
      while (n < PHASE_ITEMS) begin
        kind = $urandom_range(0, 5);
        run = $urandom_range(1, 20);
        repeat (run) begin
          pending_samples.push_back(draw_sample(kind));
          n++;
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
